/* sv/fdt_struct_token_parser_defines.svh */
// Assertion macros shared by the structure block parser RTL.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef FDT_STRUCT_TOKEN_PARSER_DEFINES_SVH
`define FDT_STRUCT_TOKEN_PARSER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FDT_STP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define FDT_STP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/fdt_stp_pkg.sv */
// Types and constants for the device tree structure block parser.
// No dependencies; used by fdt_stp_parse and fdt_struct_token_parser.
`timescale 1ns / 1ps
`default_nettype none

package fdt_stp_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned SIZE_W   = 24;
  localparam int unsigned COUNT_W  = 22;
  localparam int unsigned VLEFT_W  = 30;

  localparam logic [SIZE_W-1:0]  SIZE_RESET = 24'hFF_FFFF;
  localparam logic [COUNT_W-1:0] COUNT_MAX  = 22'h3F_FFFF;

  localparam logic [WORD_W-1:0] TOK_BEGIN_NODE = 32'd1;
  localparam logic [WORD_W-1:0] TOK_END_NODE   = 32'd2;
  localparam logic [WORD_W-1:0] TOK_PROP       = 32'd3;
  localparam logic [WORD_W-1:0] TOK_END        = 32'd9;

  typedef enum logic [2:0] {
    PH_TOKEN,
    PH_NAME,
    PH_PLEN,
    PH_POFF,
    PH_VALUE,
    PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    EV_BEGIN,
    EV_NAME,
    EV_END,
    EV_PROP,
    EV_VALUE,
    EV_TREE_END
  } event_t;

  typedef struct packed {
    logic              valid;
    event_t            ev;
    logic [WORD_W-1:0] data;
    logic [WORD_W-1:0] prop_length;
    logic [WORD_W-1:0] name_offset;
    logic              last;
  } result_t;

endpackage

`default_nettype wire

/* sv/fdt_stp_parse.sv */
// Parser state and per-word token decode for the structure block.
// Depends on fdt_stp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fdt_stp_parse (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                step,
  input  logic [fdt_stp_pkg::WORD_W-1:0]      word,
  input  logic                                first,
  input  logic [fdt_stp_pkg::SIZE_W-1:0]      size_bytes,
  output fdt_stp_pkg::result_t                res
);
  import fdt_stp_pkg::*;

  phase_t               phase_r, phase_nxt;
  logic [COUNT_W-1:0]   wc_r, wc_nxt;
  logic [VLEFT_W-1:0]   vleft_r, vleft_nxt;
  logic [WORD_W-1:0]    hlen_r, hlen_nxt;

  phase_t               phase_cur;
  logic [COUNT_W-1:0]   wc_cur;
  logic [VLEFT_W-1:0]   vleft_cur;
  logic [WORD_W-1:0]    hlen_cur;
  logic [WORD_W-1:0]    hlen_m1;
  logic                 in_range;
  logic                 active;
  logic                 zero_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TOKEN;
      wc_r    <= '0;
      vleft_r <= '0;
      hlen_r  <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      wc_r    <= wc_nxt;
      vleft_r <= vleft_nxt;
      hlen_r  <= hlen_nxt;
    end
  end

  always_comb begin
    // a first word restarts the parser before it is decoded
    phase_cur = first ? PH_TOKEN : phase_r;
    wc_cur    = first ? '0 : wc_r;
    vleft_cur = first ? '0 : vleft_r;
    hlen_cur  = first ? '0 : hlen_r;

    in_range  = {wc_cur, 2'b00} < size_bytes;
    active    = (phase_cur != PH_DONE) && in_range;
    zero_byte = (word[7:0] == 8'h00) || (word[15:8] == 8'h00) ||
                (word[23:16] == 8'h00) || (word[31:24] == 8'h00);
    hlen_m1   = hlen_cur - 32'd1;

    phase_nxt = phase_cur;
    wc_nxt    = wc_cur;
    vleft_nxt = vleft_cur;
    hlen_nxt  = hlen_cur;

    res             = '0;
    res.ev          = EV_BEGIN;

    if (active) begin
      case (phase_cur)
        PH_TOKEN: begin
          if (word == TOK_BEGIN_NODE) begin
            phase_nxt = PH_NAME;
            res.valid = 1'b1;
            res.ev    = EV_BEGIN;
          end else if (word == TOK_END_NODE) begin
            res.valid = 1'b1;
            res.ev    = EV_END;
          end else if (word == TOK_PROP) begin
            phase_nxt = PH_PLEN;
          end else if (word == TOK_END) begin
            phase_nxt = PH_DONE;
            res.valid = 1'b1;
            res.ev    = EV_TREE_END;
          end
        end
        PH_NAME: begin
          res.valid = 1'b1;
          res.ev    = EV_NAME;
          res.data  = word;
          res.last  = zero_byte;
          if (zero_byte) begin
            phase_nxt = PH_TOKEN;
          end
        end
        PH_PLEN: begin
          hlen_nxt  = word;
          phase_nxt = PH_POFF;
        end
        PH_POFF: begin
          res.valid       = 1'b1;
          res.ev          = EV_PROP;
          res.prop_length = hlen_cur;
          res.name_offset = word;
          if (hlen_cur == '0) begin
            phase_nxt = PH_TOKEN;
          end else begin
            // hold value word count minus one
            vleft_nxt = hlen_m1[WORD_W-1:2];
            phase_nxt = PH_VALUE;
          end
        end
        PH_VALUE: begin
          res.valid = 1'b1;
          res.ev    = EV_VALUE;
          res.data  = word;
          if (vleft_cur == '0) begin
            res.last  = 1'b1;
            phase_nxt = PH_TOKEN;
          end else begin
            vleft_nxt = vleft_cur - VLEFT_W'(1);
          end
        end
        default: begin
          phase_nxt = PH_DONE;
        end
      endcase

      // past the last countable word nothing can lie inside the block
      if (wc_cur == COUNT_MAX) begin
        phase_nxt = PH_DONE;
      end else begin
        wc_nxt = wc_cur + COUNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* sv/fdt_struct_token_parser.sv */
// Top level of the flattened device tree structure block parser.
// Depends on fdt_stp_pkg, fdt_stp_parse and fdt_struct_token_parser_defines.svh.
//
// Usage:
//   Input channel (in_valid / in_stall): one structure block word per item,
//   first memory byte in in_word[31:24]. in_first marks word 0 of a block
//   and restarts the parser. An item is taken at a clock edge with in_valid
//   high and in_stall low.
//   Result channel (out_valid / out_stall): at most one result item per
//   input item (node begin, name word, node end, property header, value
//   word, tree end). Words that produce nothing are dropped silently.
//   Config: cfg_wr_en / cfg_wr_data write the structure size in bytes;
//   write only while the block is idle.
// Timing:
//   An accepted item waits in the input register until the output register is
//   free or being emptied, then its decode is loaded into the output register,
//   from which the receiver takes it.
//   One item per cycle is sustained while out_stall stays low; the token
//   decode in fdt_stp_parse is combinational, its state updates on each step.
// Reset: synchronous, active low. Clears the valid flags of both pipeline
//   registers, returns the parser to token state and sets the size to its maximum.
// Stall: a stalled result holds in the output register; the input register
//   then fills and in_stall rises until the receiver takes the result.
`timescale 1ns / 1ps
`default_nettype none
`include "fdt_struct_token_parser_defines.svh"

module fdt_struct_token_parser (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_wr_en,
  input  logic [fdt_stp_pkg::SIZE_W-1:0]    cfg_wr_data,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [fdt_stp_pkg::WORD_W-1:0]    in_word,
  input  logic                              in_first,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [2:0]                        out_event_res,
  output logic [fdt_stp_pkg::WORD_W-1:0]    out_data,
  output logic [fdt_stp_pkg::WORD_W-1:0]    out_prop_length,
  output logic [fdt_stp_pkg::WORD_W-1:0]    out_name_offset,
  output logic                              out_last
);
  import fdt_stp_pkg::*;

  // structure size register
  logic [SIZE_W-1:0]  size_r;

  // input register stage
  logic               s1_valid_r, s1_valid_nxt;
  logic [WORD_W-1:0]  s1_word_r;
  logic               s1_first_r;

  // output register stage
  logic               out_valid_r, out_valid_nxt;
  result_t            out_r;

  logic               in_take;
  logic               s1_adv;
  logic               step;
  result_t            res;

  // the output register is free, or being emptied this cycle
  assign s1_adv   = !out_valid_r || !out_stall;
  assign step     = s1_valid_r && s1_adv;
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SIZE_RESET;
    end else if (cfg_wr_en) begin
      size_r <= cfg_wr_data;
    end
  end

  // input register: load on accept, drain when the item advances
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (step) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_word_r  <= in_word;
      s1_first_r <= in_first;
    end
  end

  fdt_stp_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .word       (s1_word_r),
    .first      (s1_first_r),
    .size_bytes (size_r),
    .res        (res)
  );

  // output register: load the decode when the item advances, drop once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step) begin
      out_valid_nxt = res.valid;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res.valid) begin
      out_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_event_res   = out_r.ev;
  assign out_data        = out_r.data;
  assign out_prop_length = out_r.prop_length;
  assign out_name_offset = out_r.name_offset;
  assign out_last        = out_r.last;

  // an accepted word never lands on an input register that still holds one
  `FDT_STP_ASSERT_NOW(a_no_overwrite, in_take && s1_valid_r, step, "input register overwritten")
  // a stalled result is never replaced by a new decode
  `FDT_STP_ASSERT_NOW(a_out_hold, out_valid_r && out_stall, !step, "stalled result replaced")
  // only name and value words carry the last mark
  `FDT_STP_ASSERT_NOW(a_last_kind, out_valid_r && out_r.last,
                      out_r.ev == EV_NAME || out_r.ev == EV_VALUE, "last on wrong event")
  // a property header is the only result with a length or offset
  `FDT_STP_ASSERT_NEXT(a_hdr_fields, step && res.valid && res.ev != EV_PROP,
                       out_r.prop_length == '0 && out_r.name_offset == '0,
                       "header fields on non-header result")

endmodule

`default_nettype wire

/* verif/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for fdt_struct_token_parser: streams structure block words,
// predicts every event item in a local parser and checks the result channel.
// Depends on fdt_stp_pkg and the parser RTL; reads no files.

module testbench;
  import fdt_stp_pkg::*;

  // Generous bound: ~600 words, each with a full sender gap and receiver stall,
  // plus the long hold-off and reset, taken several times over.
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned MAX_WAIT     = 18;
  localparam int unsigned LONG_HOLD    = 300;
  // A result follows its word through the input and output registers; drain further.
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned ERR_SHOWN    = 10;
  // No package constant for the no-op token.
  localparam logic [WORD_W-1:0] TOK_NOP = 32'd4;

  typedef enum int {IDLE_NONE, IDLE_SOME, IDLE_FULL} idle_mode_t;

  typedef struct {
    logic [WORD_W-1:0] word;
    logic              first;
  } struct_word_t;

  typedef struct {
    event_t            ev;
    logic [WORD_W-1:0] data;
    logic [WORD_W-1:0] prop_length;
    logic [WORD_W-1:0] name_offset;
    logic              last;
  } tree_event_t;

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT
  // ---------------------------------------------------------------------------
  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              cfg_wr_en   = 1'b0;
  logic [SIZE_W-1:0] cfg_wr_data = '0;
  logic              in_valid    = 1'b0;
  logic [WORD_W-1:0] in_word     = '0;
  logic              in_first    = 1'b0;
  logic              out_stall   = 1'b0;
  logic              in_stall;
  logic              out_valid;
  logic [2:0]        out_event_res;
  logic [WORD_W-1:0] out_data;
  logic [WORD_W-1:0] out_prop_length;
  logic [WORD_W-1:0] out_name_offset;
  logic              out_last;

  always #10 clk = ~clk;

  fdt_struct_token_parser i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_word         (in_word),
    .in_first        (in_first),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_event_res   (out_event_res),
    .out_data        (out_data),
    .out_prop_length (out_prop_length),
    .out_name_offset (out_name_offset),
    .out_last        (out_last)
  );

  // ---------------------------------------------------------------------------
  // Shared testbench state
  // ---------------------------------------------------------------------------
  struct_word_t word_queue[$];       // items waiting for the driver
  tree_event_t  expected_events[$];  // predicted events, oldest first
  int unsigned  words_sent  = 0;
  int unsigned  err_count   = 0;
  int unsigned  cycle_count = 0;
  bit           in_took     = 1'b0;  // input item taken at the last rising edge
  bit           out_took    = 1'b0;  // result item taken at the last rising edge
  idle_mode_t   tx_mode     = IDLE_NONE;
  idle_mode_t   rx_mode     = IDLE_NONE;
  int           hold_req    = 0;     // bumped to request one long receiver hold-off

  // ---------------------------------------------------------------------------
  // Parser prediction: own copy of the walk state and the size register
  // ---------------------------------------------------------------------------
  phase_t             walk_phase    = PH_TOKEN;
  logic [COUNT_W-1:0] words_seen    = '0;
  logic [VLEFT_W-1:0] values_to_go  = '0;   // value words still due, minus one
  logic [WORD_W-1:0]  prop_len_held = '0;
  logic [SIZE_W-1:0]  block_size    = SIZE_RESET;

  function automatic bit zero_byte_in(logic [WORD_W-1:0] w);
    return (w[31:24] == 8'h00) || (w[23:16] == 8'h00) ||
           (w[15:8] == 8'h00) || (w[7:0] == 8'h00);
  endfunction

  function automatic void expect_event(event_t ev, logic [WORD_W-1:0] data,
                                       logic [WORD_W-1:0] len,
                                       logic [WORD_W-1:0] off, logic last);
    expected_events.push_back('{ev, data, len, off, last});
  endfunction

  // Advance the predicted walk by one accepted word.
  function automatic void track_word(logic [WORD_W-1:0] w, logic first);
    bit ends_name;
    ends_name = zero_byte_in(w);
    if (first) begin
      walk_phase    = PH_TOKEN;
      words_seen    = '0;
      values_to_go  = '0;
      prop_len_held = '0;
    end
    // Drop everything after tree end and everything past the block size.
    if (walk_phase == PH_DONE) return;
    if ({words_seen, 2'b00} >= block_size) return;
    case (walk_phase)
      PH_TOKEN: begin
        if (w == TOK_BEGIN_NODE) begin
          walk_phase = PH_NAME;
          expect_event(EV_BEGIN, '0, '0, '0, 1'b0);
        end else if (w == TOK_END_NODE) begin
          expect_event(EV_END, '0, '0, '0, 1'b0);
        end else if (w == TOK_PROP) begin
          walk_phase = PH_PLEN;
        end else if (w == TOK_END) begin
          walk_phase = PH_DONE;
          expect_event(EV_TREE_END, '0, '0, '0, 1'b0);
        end
      end
      PH_NAME: begin
        if (ends_name) walk_phase = PH_TOKEN;
        expect_event(EV_NAME, w, '0, '0, ends_name);
      end
      PH_PLEN: begin
        prop_len_held = w;
        walk_phase    = PH_POFF;
      end
      PH_POFF: begin
        expect_event(EV_PROP, '0, prop_len_held, w, 1'b0);
        if (prop_len_held == '0) begin
          walk_phase = PH_TOKEN;
        end else begin
          values_to_go = VLEFT_W'((prop_len_held - 1) >> 2);
          walk_phase   = PH_VALUE;
        end
      end
      PH_VALUE: begin
        expect_event(EV_VALUE, w, '0, '0, values_to_go == '0);
        if (values_to_go == '0) walk_phase = PH_TOKEN;
        else values_to_go = values_to_go - 1'b1;
      end
      default: walk_phase = PH_DONE;
    endcase
    // A full word counter means no later word fits in a 24-bit size.
    if (words_seen == COUNT_MAX) walk_phase = PH_DONE;
    else words_seen = words_seen + 1'b1;
  endfunction

  function automatic void flag_error(string msg);
    err_count++;
    if (err_count <= ERR_SHOWN) $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endfunction

  // Compare the result item on the port with the oldest prediction.
  function automatic void check_event();
    tree_event_t want;
    if (expected_events.size() == 0) begin
      flag_error($sformatf("unexpected event %0d data %h len %h off %h last %b",
                           out_event_res, out_data, out_prop_length, out_name_offset,
                           out_last));
      return;
    end
    want = expected_events.pop_front();
    if (out_event_res !== 3'(want.ev) || out_data !== want.data ||
        out_prop_length !== want.prop_length || out_name_offset !== want.name_offset ||
        out_last !== want.last)
      flag_error($sformatf("got %0d %h %h %h %b, want %0d %h %h %h %b",
                           out_event_res, out_data, out_prop_length, out_name_offset,
                           out_last, want.ev, want.data, want.prop_length,
                           want.name_offset, want.last));
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: sample both handshakes at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cycle_count++;
    in_took  = rst_n && in_valid && !in_stall;
    out_took = rst_n && out_valid && !out_stall;
    if (in_took) track_word(in_word, in_first);
    if (out_took) check_event();
  end

  function automatic int unsigned draw_wait(idle_mode_t mode);
    case (mode)
      IDLE_NONE: return 0;
      IDLE_SOME: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_WAIT) : 0;
      default:   return $urandom_range(0, MAX_WAIT);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: feed items from word_queue at the falling edge
  // ---------------------------------------------------------------------------
  int unsigned gap_left = 0;

  always @(negedge clk) begin
    struct_word_t item;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !in_took)) begin
      // Hold a stalled item as is; otherwise idle out the gap, then advance.
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (word_queue.size() > 0) begin
        item = word_queue.pop_front();
        in_word  <= item.word;
        in_first <= item.first;
        in_valid <= 1'b1;
        gap_left = draw_wait(tx_mode);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: a fresh stall draw per result item, plus the long hold-off
  // ---------------------------------------------------------------------------
  int unsigned stall_left = 0;
  int unsigned hold_left  = 0;
  int          hold_seen  = 0;

  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = LONG_HOLD;
    end
    if (out_took) stall_left = draw_wait(rx_mode);
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void send(logic [WORD_W-1:0] w, logic first);
    word_queue.push_back('{w, first});
    words_sent++;
  endfunction

  function automatic logic [WORD_W-1:0] name_chars();
    return {8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
            8'($urandom_range(1, 255)), 8'($urandom_range(1, 255))};
  endfunction

  // A closing name word: random bytes with one or more of them cleared.
  function automatic logic [WORD_W-1:0] name_tail();
    logic [WORD_W-1:0] w;
    logic [3:0]        zeros;
    w     = $urandom;
    zeros = 4'($urandom_range(1, 15));
    for (int i = 0; i < 4; i++) if (zeros[i]) w[8*i +: 8] = 8'h00;
    return w;
  endfunction

  function automatic void send_name();
    repeat ($urandom_range(0, 3)) send(name_chars(), 1'b0);
    send(name_tail(), 1'b0);
  endfunction

  // One well-formed tree with random content, mixed with noise and restarts.
  function automatic void random_block(int unsigned budget);
    int unsigned depth;
    int unsigned start;
    int unsigned pick;
    logic [WORD_W-1:0] len;
    start = words_sent;
    send(TOK_BEGIN_NODE, 1'b1);
    send_name();
    depth = 1;
    while (words_sent - start < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 22) begin
        send(TOK_BEGIN_NODE, 1'b0);
        send_name();
        depth++;
      end else if (pick < 52) begin
        len = ($urandom_range(0, 24) == 0) ? $urandom : $urandom_range(0, 24);
        send(TOK_PROP, 1'b0);
        send(len, 1'b0);
        send($urandom, 1'b0);
        if (len > 64) begin
          // Huge property: cut it short, the next block restarts the parser.
          repeat ($urandom_range(0, 4)) send($urandom, 1'b0);
          return;
        end
        repeat ((len + 3) / 4) send($urandom, 1'b0);
      end else if (pick < 72) begin
        if (depth > 0) begin
          send(TOK_END_NODE, 1'b0);
          depth--;
        end
      end else if (pick < 80) begin
        send(TOK_NOP, 1'b0);
      end else if (pick < 88) begin
        send($urandom, 1'b0);
      end else if (pick < 95) begin
        send($urandom_range(0, 15), 1'b0);
      end else begin
        // Broken sequence: restart in the middle of the tree.
        send($urandom_range(0, 10), 1'b1);
        depth = 0;
      end
    end
    while (depth > 0) begin
      send(TOK_END_NODE, 1'b0);
      depth--;
    end
    send(TOK_END, 1'b0);
    repeat ($urandom_range(0, 3)) send($urandom, 1'b0);
  endfunction

  task automatic write_block_size(logic [SIZE_W-1:0] size);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= size;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    block_size = size;
  endtask

  // Wait until every item is taken and every prediction met, then drain.
  task automatic settle();
    while (word_queue.size() != 0 || in_valid) @(posedge clk);
    while (expected_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Watchdog
  // ---------------------------------------------------------------------------
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("testbench: errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed words at the reset size: every token, name endings with a zero in the
    // first, second or last byte, empty and short properties, tree end and restarts.
    tx_mode = IDLE_SOME;
    rx_mode = IDLE_SOME;
    send(TOK_BEGIN_NODE, 1'b1);
    send(32'h0000_0000, 1'b0);       // empty root name
    send(TOK_BEGIN_NODE, 1'b0);
    send(32'h4142_4344, 1'b0);
    send(32'h0045_4647, 1'b0);       // zero in the first byte
    send(TOK_BEGIN_NODE, 1'b0);
    send(32'h6100_6263, 1'b0);       // zero in the second byte
    send(TOK_PROP, 1'b0);
    send(32'd0, 1'b0);               // empty property: header only
    send(32'hFFFF_FFFF, 1'b0);
    send(TOK_PROP, 1'b0);
    send(32'd5, 1'b0);               // two value words
    send(32'h0000_0000, 1'b0);
    send(32'hFFFF_FFFF, 1'b0);
    send(32'h1234_5600, 1'b0);
    send(TOK_NOP, 1'b0);
    send(32'h0000_0000, 1'b0);       // unknown tokens
    send(32'hFFFF_FFFF, 1'b0);
    send(TOK_END_NODE, 1'b0);
    send(TOK_END_NODE, 1'b0);
    send(TOK_END, 1'b0);
    send(TOK_BEGIN_NODE, 1'b0);      // ignored after tree end
    send(TOK_PROP, 1'b1);            // maximum length, cut by a restart
    send(32'hFFFF_FFFF, 1'b0);
    send(32'h0000_0007, 1'b0);
    send($urandom, 1'b0);
    send(TOK_BEGIN_NODE, 1'b1);
    send(32'h6162_6300, 1'b0);       // zero in the last byte
    settle();

    // Zero size: every word past the block.
    write_block_size('0);
    send(TOK_BEGIN_NODE, 1'b1);
    send(TOK_END_NODE, 1'b0);
    send(TOK_END, 1'b1);
    settle();

    // Size not a multiple of four: words at offsets 0..12 count, the rest drop.
    write_block_size(24'd13);
    send(TOK_BEGIN_NODE, 1'b1);
    send(32'h4142_4344, 1'b0);
    send(32'h4546_4748, 1'b0);
    send(32'h0000_0000, 1'b0);
    send(TOK_END, 1'b0);
    send(TOK_PROP, 1'b1);
    send(32'd8, 1'b0);
    send(32'h0000_0010, 1'b0);
    send(32'hDEAD_BEEF, 1'b0);
    send(32'hCAFE_F00D, 1'b0);       // second value word lies past the block
    settle();

    // Random trees across several sizes and idle patterns.
    for (int phase_no = 0; phase_no < 6; phase_no++) begin
      int unsigned target;
      case (phase_no)
        0: begin tx_mode = IDLE_FULL; rx_mode = IDLE_FULL; end
        1: begin tx_mode = IDLE_NONE; rx_mode = IDLE_NONE; end
        2: begin tx_mode = IDLE_NONE; rx_mode = IDLE_SOME; end
        3: begin tx_mode = IDLE_SOME; rx_mode = IDLE_FULL; end
        4: begin tx_mode = IDLE_FULL; rx_mode = IDLE_NONE; end
        default: begin tx_mode = IDLE_SOME; rx_mode = IDLE_SOME; end
      endcase
      if (phase_no == 3 || phase_no == 4) write_block_size(24'($urandom_range(8, 400)));
      else write_block_size(SIZE_RESET);
      target = words_sent + 60;
      while (words_sent < target) random_block($urandom_range(8, 60));
      // Hold off the receiver while the sender streams, so the block backs up.
      if (phase_no == 2) hold_req++;
      settle();
    end

    if (expected_events.size() != 0) begin
      flag_error($sformatf("%0d predicted events never arrived", expected_events.size()));
    end
    if (err_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
